>>> src/nred_pkg.sv
`timescale 1ns / 1ps

package nred_pkg;

	localparam int NUM_PASSENGERS_DEF = 16;
	localparam int NUM_FLOORS_DEF     = 16;

	localparam logic [15:0] TRIPS_RST = 16'd16;
	localparam logic [3:0]  START_RST = 4'd0;

	typedef enum logic [1:0] {
		CMD_REQUEST = 2'd0,
		CMD_ENTERED = 2'd1,
		CMD_EXITED  = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_UP    = 3'd1,
		ACT_DOWN  = 3'd2,
		ACT_OPEN  = 3'd3,
		ACT_CLOSE = 3'd4,
		ACT_DONE  = 3'd5
	} act_t;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_TO_PICKUP = 5'b00010,
		PH_AT_PICKUP = 5'b00100,
		PH_TO_DEST   = 5'b01000,
		PH_AT_DEST   = 5'b10000
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} seq_t;

	localparam int CFG_TOTAL_TRIPS = 0;
	localparam int CFG_START_FLOOR = 1;

endpackage

>>> src/nearest_request_elevator_dispatch_top.sv
`timescale 1ns / 1ps

// Single-car elevator dispatcher serving one passenger at a time.
// Input channel (in_valid / in_stall) carries one command per transaction:
// a request, a passenger entered or exited event, or a tick. The output
// channel (out_valid / out_stall) returns exactly one result per input
// transaction: the action taken, the car floor and the served passenger slot.
// A tick that finds the car idle with trips left scans every passenger slot
// through one shared distance compare, one slot per cycle, then passes a
// drain state before the finish state registers its result. Any other command
// goes from acceptance straight to the finish state.
// in_stall is high while a transaction is being worked on, so the block
// handles one transaction at a time. A finished result waits in the output
// register while out_stall is high; the next command may then be accepted and
// worked on, and its result is held back until the output register is free.
// Asynchronous reset clears all waiting marks, puts the car at floor 0 with
// 16 trips to go and empties the output register. The configuration port
// writes the trip count or the start floor into the trip counter or the car
// floor; users write it only while the block is idle, which is not enforced.
module nearest_request_elevator_dispatch_top #(
	parameter int NUM_PASSENGERS = nred_pkg::NUM_PASSENGERS_DEF,
	parameter int NUM_FLOORS     = nred_pkg::NUM_FLOORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  passenger_id,
	input  logic [3:0]  src_floor,
	input  logic [3:0]  dst_floor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [3:0]  car_floor,
	output logic [3:0]  served_passenger
);
	import nred_pkg::*;

	localparam int PW = (NUM_PASSENGERS > 1) ? $clog2(NUM_PASSENGERS) : 1;

	function automatic logic [3:0] clamp_floor(input logic [3:0] f);
		if (32'(f) > NUM_FLOORS - 1) begin
			return 4'(NUM_FLOORS - 1);
		end
		return f;
	endfunction

	seq_t        seq_q;
	cmd_t        cmd_q;
	logic [3:0]  id_q;
	logic [3:0]  from_q;
	logic [3:0]  to_q;

	logic [NUM_PASSENGERS-1:0] waiting_q;
	logic [7:0]  slot_mem [NUM_PASSENGERS];
	logic [7:0]  rd_q;
	logic [PW-1:0] rd_addr;

	phase_t      phase_q;
	logic [3:0]  cur_q;
	logic [3:0]  tgt_q;
	logic [3:0]  srv_q;
	logic [15:0] trips_q;

	logic [PW-1:0] scan_q;
	logic          cmp_vld_s1;
	logic          cmp_wait_s1;
	logic [PW-1:0] cmp_idx_s1;
	logic          found_q;
	logic [3:0]    best_dist_q;
	logic [PW-1:0] best_idx_q;
	logic [3:0]    best_floor_q;

	logic        out_valid_q;
	act_t        action_q;
	logic [3:0]  car_floor_q;
	logic [3:0]  served_q;

	logic        out_free;
	logic        id_ok;
	logic [3:0]  gap;
	logic        take;

	act_t        act_d;
	phase_t      ph_d;
	logic [3:0]  cur_d;
	logic [3:0]  tgt_d;
	logic [3:0]  srv_d;
	logic [15:0] trips_d;
	logic        wait_set;
	logic        wait_clr;
	logic        mem_we;

	assign in_stall         = (seq_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign action           = action_q;
	assign car_floor        = car_floor_q;
	assign served_passenger = served_q;

	assign out_free = !out_valid_q || !out_stall;
	assign id_ok    = (32'(id_q) < NUM_PASSENGERS);
	assign rd_addr  = (seq_q == ST_SCAN) ? scan_q : PW'(srv_q);

	// Shared distance compare used once per scanned slot.
	assign gap  = (rd_q[7:4] > cur_q) ? (rd_q[7:4] - cur_q) : (cur_q - rd_q[7:4]);
	assign take = cmp_vld_s1 && cmp_wait_s1 && (!found_q || (gap < best_dist_q));

	always_comb begin
		act_d    = ACT_NONE;
		ph_d     = phase_q;
		cur_d    = cur_q;
		tgt_d    = tgt_q;
		srv_d    = srv_q;
		trips_d  = trips_q;
		wait_set = 1'b0;
		wait_clr = 1'b0;
		mem_we   = 1'b0;
		if (trips_q == 16'd0) begin
			act_d = ACT_DONE;
		end else begin
			unique case (cmd_q)
				CMD_REQUEST: begin
					if (id_ok) begin
						wait_set = 1'b1;
						mem_we   = 1'b1;
					end
				end
				CMD_ENTERED: begin
					if (id_ok && phase_q == PH_AT_PICKUP && id_q == srv_q) begin
						tgt_d = rd_q[3:0];
						ph_d  = PH_TO_DEST;
						act_d = ACT_CLOSE;
					end
				end
				CMD_EXITED: begin
					if (id_ok && phase_q == PH_AT_DEST && id_q == srv_q) begin
						trips_d = trips_q - 16'd1;
						ph_d    = PH_IDLE;
						act_d   = ACT_CLOSE;
					end
				end
				CMD_TICK: begin
					if (phase_q == PH_IDLE) begin
						if (found_q) begin
							wait_clr = 1'b1;
							srv_d    = 4'(best_idx_q);
							tgt_d    = best_floor_q;
							ph_d     = PH_TO_PICKUP;
						end
					end else if (phase_q == PH_TO_PICKUP || phase_q == PH_TO_DEST) begin
						if (cur_q < tgt_q) begin
							cur_d = cur_q + 4'd1;
							act_d = ACT_UP;
						end else if (cur_q > tgt_q) begin
							cur_d = cur_q - 4'd1;
							act_d = ACT_DOWN;
						end else begin
							ph_d  = (phase_q == PH_TO_PICKUP) ? PH_AT_PICKUP : PH_AT_DEST;
							act_d = ACT_OPEN;
						end
					end
				end
				default: act_d = ACT_NONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q        <= slot_mem[rd_addr];
		cmp_idx_s1  <= scan_q;
		cmp_wait_s1 <= waiting_q[scan_q];
		if (seq_q == ST_FINISH && out_free && mem_we) begin
			slot_mem[PW'(id_q)] <= {clamp_floor(from_q), clamp_floor(to_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == ST_IDLE && in_valid) begin
			cmd_q  <= cmd_t'(command);
			id_q   <= passenger_id;
			from_q <= src_floor;
			to_q   <= dst_floor;
		end
		if (take) begin
			best_dist_q  <= gap;
			best_idx_q   <= cmp_idx_s1;
			best_floor_q <= rd_q[7:4];
		end
		if (seq_q == ST_FINISH && out_free) begin
			action_q    <= act_d;
			car_floor_q <= cur_d;
			served_q    <= srv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= ST_IDLE;
			waiting_q   <= '0;
			phase_q     <= PH_IDLE;
			cur_q       <= clamp_floor(START_RST);
			tgt_q       <= 4'd0;
			srv_q       <= 4'd0;
			trips_q     <= TRIPS_RST;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (seq_q == ST_SCAN);
			if (take) begin
				found_q <= 1'b1;
			end
			if (out_valid_q && !out_stall && seq_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (seq_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						if (cmd_t'(command) == CMD_TICK && phase_q == PH_IDLE
							&& trips_q != 16'd0) begin
							seq_q <= ST_SCAN;
						end else begin
							seq_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + PW'(1);
					if (scan_q == PW'(NUM_PASSENGERS - 1)) begin
						seq_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					seq_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						seq_q       <= ST_IDLE;
						out_valid_q <= 1'b1;
						phase_q     <= ph_d;
						cur_q       <= cur_d;
						tgt_q       <= tgt_d;
						srv_q       <= srv_d;
						trips_q     <= trips_d;
						if (wait_set) begin
							waiting_q[PW'(id_q)] <= 1'b1;
						end
						if (wait_clr) begin
							waiting_q[best_idx_q] <= 1'b0;
						end
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				if (32'(cfg_index) == CFG_TOTAL_TRIPS) begin
					trips_q <= cfg_data;
				end else begin
					cur_q <= clamp_floor(cfg_data[3:0]);
				end
			end
		end
	end

endmodule
